FILE: hw/rtl/line_rasterizer_clipped_defines.svh
// Assertion macros for the line rasterizer RTL.
// Needs clock and reset in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef LINE_RASTERIZER_CLIPPED_DEFINES_SVH
`define LINE_RASTERIZER_CLIPPED_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LRC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LRC_ASSERT_IMPL(label, ante, cons, msg)
`define LRC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/lrc_pkg.sv
// Shared types and constants of the line rasterizer.
// No dependencies; used by every module of the block.
package lrc_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_FB_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FB_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_PITCH = 2'd2;
   localparam logic [1:0] CSR_BPP       = 2'd3;

   // pixel formats
   localparam logic [5:0] BPP_8  = 6'd8;
   localparam logic [5:0] BPP_16 = 6'd16;
   localparam logic [5:0] BPP_24 = 6'd24;
   localparam logic [5:0] BPP_32 = 6'd32;

   typedef struct packed {
      logic               command;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic [31:0]        line_color;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic               inside_res;
      logic [31:0]        byte_offset;
      logic [31:0]        pixel_data;
      logic [2:0]         byte_count;
      logic               last_pixel;
   } rsp_type;

   // one line point on its way from the walker to the pixel generator
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
      logic [31:0]        color;
   } pt_type;

   typedef struct packed {
      logic [14:0] fb_width;
      logic [14:0] fb_height;
      logic [16:0] row_pitch;
      logic [5:0]  bits_per_pixel;
   } cfg_type;

endpackage

FILE: hw/rtl/lrc_walker.sv
// Bresenham walker: line state, one step per request, point stage register.
// Depends on lrc_pkg and line_rasterizer_clipped_defines.svh.
`include "line_rasterizer_clipped_defines.svh"

module lrc_walker #(
   parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lrc_pkg::req_type req_payload,
   output logic             pt_valid,
   input  logic             pt_ready,
   output lrc_pkg::pt_type  pt
);

   localparam int W   = COORD_BITS;
   localparam int DW  = COORD_BITS + 1;
   localparam int EW  = COORD_BITS + 3;
   localparam int E2W = COORD_BITS + 4;

   logic                  active_ff, active_in;
   logic signed [W-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [W-1:0]   goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [DW-1:0]  delta_x_ff, delta_x_in, neg_dy_ff, neg_dy_in;
   logic                  step_x_neg_ff, step_x_neg_in, step_y_neg_ff, step_y_neg_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic [31:0]           color_ff, color_in;
   logic                  pt_valid_ff, pt_valid_in;
   lrc_pkg::pt_type       pt_ff, pt_in;

   logic                  fire;
   logic                  emit;
   logic signed [W-1:0]   ld_sx, ld_sy, ld_gx, ld_gy;
   logic signed [DW-1:0]  ld_dx, ld_dy;
   logic signed [E2W-1:0] st_e2;
   logic                  move_x, move_y;

   assign req_ready = !pt_valid_ff || pt_ready;
   assign fire      = req_valid && req_ready;
   assign pt_valid  = pt_valid_ff;
   assign pt        = pt_ff;

   // endpoints keep the low coordinate bits as two's complement
   assign ld_sx = req_payload.start_x[W-1:0];
   assign ld_sy = req_payload.start_y[W-1:0];
   assign ld_gx = req_payload.end_x[W-1:0];
   assign ld_gy = req_payload.end_y[W-1:0];
   assign ld_dx = DW'(ld_gx) - DW'(ld_sx);
   assign ld_dy = DW'(ld_gy) - DW'(ld_sy);

   assign st_e2  = {err_ff, 1'b0};
   assign move_x = st_e2 >= E2W'(neg_dy_ff);
   assign move_y = st_e2 <= E2W'(delta_x_ff);

   always_comb begin
      active_in     = active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      delta_x_in    = delta_x_ff;
      neg_dy_in     = neg_dy_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      err_in        = err_ff;
      color_in      = color_ff;
      emit          = 1'b0;
      if (fire && req_payload.command == lrc_pkg::CMD_LOAD) begin
         emit          = 1'b1;
         cur_x_in      = ld_sx;
         cur_y_in      = ld_sy;
         goal_x_in     = ld_gx;
         goal_y_in     = ld_gy;
         delta_x_in    = ld_dx[DW-1] ? -ld_dx : ld_dx;
         neg_dy_in     = ld_dy[DW-1] ? ld_dy : -ld_dy;
         step_x_neg_in = !(ld_sx < ld_gx);
         step_y_neg_in = !(ld_sy < ld_gy);
         err_in        = EW'(delta_x_in) + EW'(neg_dy_in);
         color_in      = req_payload.line_color;
      end else if (fire && active_ff) begin
         emit = 1'b1;
         if (move_x) begin
            err_in   = err_in + EW'(neg_dy_ff);
            cur_x_in = step_x_neg_ff ? cur_x_ff - W'(1) : cur_x_ff + W'(1);
         end
         if (move_y) begin
            err_in   = err_in + EW'(delta_x_ff);
            cur_y_in = step_y_neg_ff ? cur_y_ff - W'(1) : cur_y_ff + W'(1);
         end
      end
      // drop out of the walk once the end point is reached
      if (emit) begin
         active_in = !(cur_x_in == goal_x_in && cur_y_in == goal_y_in);
      end
   end

   always_comb begin
      pt_in.x     = 16'(cur_x_in);
      pt_in.y     = 16'(cur_y_in);
      pt_in.last  = !active_in;
      pt_in.color = color_in;
      if (fire) begin
         pt_valid_in = emit;
      end else if (pt_ready) begin
         pt_valid_in = 1'b0;
      end else begin
         pt_valid_in = pt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         delta_x_ff    <= '0;
         neg_dy_ff     <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         err_ff        <= '0;
         color_ff      <= '0;
         pt_valid_ff   <= 1'b0;
      end else begin
         active_ff     <= active_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         delta_x_ff    <= delta_x_in;
         neg_dy_ff     <= neg_dy_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         err_ff        <= err_in;
         color_ff      <= color_in;
         pt_valid_ff   <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         pt_ff <= pt_in;
      end
   end

   `LRC_ASSERT_NEXT(a_load_emits, fire && req_payload.command == lrc_pkg::CMD_LOAD, pt_valid_ff, "load request produced no point")
   `LRC_ASSERT_NEXT(a_idle_step_silent, fire && req_payload.command == lrc_pkg::CMD_STEP && !active_ff, !pt_valid_ff, "step after end produced a point")
   `LRC_ASSERT_IMPL(a_active_ends_on_request, $fell(active_ff) && !$past(reset), $past(fire), "walk ended without a request")
   `LRC_ASSERT_IMPL(a_last_ends_walk, pt_valid_ff && !active_ff && $past(fire) && !$past(reset), pt_ff.last, "final point not marked last")

endmodule

FILE: hw/rtl/lrc_pixel_gen.sv
// Pixel generator: clip, byte offset, format truncation and result register.
// Depends on lrc_pkg and line_rasterizer_clipped_defines.svh.
`include "line_rasterizer_clipped_defines.svh"

module lrc_pixel_gen (
   input  logic             clock,
   input  logic             reset,
   input  lrc_pkg::cfg_type cfg,
   input  logic             pt_valid,
   output logic             pt_ready,
   input  lrc_pkg::pt_type  pt,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrc_pkg::rsp_type rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   lrc_pkg::rsp_type rsp_ff, rsp_in;

   logic             take;
   logic             in_frame;
   logic [2:0]       bytes;
   logic [31:0]      data;
   logic [31:0]      row_off;
   logic [31:0]      col_off;

   assign pt_ready    = !rsp_valid_ff || rsp_ready;
   assign take        = pt_valid && pt_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      case (cfg.bits_per_pixel)
         lrc_pkg::BPP_16: begin
            bytes = 3'd2;
            data  = {16'd0, pt.color[15:0]};
         end
         lrc_pkg::BPP_24: begin
            bytes = 3'd3;
            data  = {8'd0, pt.color[23:0]};
         end
         lrc_pkg::BPP_32: begin
            bytes = 3'd4;
            data  = pt.color;
         end
         default: begin
            bytes = 3'd1;
            data  = {24'd0, pt.color[7:0]};
         end
      endcase
   end

   // a nonnegative point fits in 15 bits, so compare there
   assign in_frame = !pt.x[15] && !pt.y[15] &&
                     (pt.x[14:0] < cfg.fb_width) && (pt.y[14:0] < cfg.fb_height);

   assign row_off = {17'd0, pt.y[14:0]} * {15'd0, cfg.row_pitch};
   assign col_off = {17'd0, pt.x[14:0]} * {29'd0, bytes};

   always_comb begin
      rsp_in.pixel_x     = pt.x;
      rsp_in.pixel_y     = pt.y;
      rsp_in.inside_res  = in_frame;
      rsp_in.byte_offset = in_frame ? row_off + col_off : 32'd0;
      rsp_in.pixel_data  = in_frame ? data : 32'd0;
      rsp_in.byte_count  = bytes;
      rsp_in.last_pixel  = pt.last;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   `LRC_ASSERT_IMPL(a_outside_zero, rsp_valid_ff && !rsp_ff.inside_res,
      rsp_ff.byte_offset == 32'd0 && rsp_ff.pixel_data == 32'd0,
      "outside pixel carries address or data")
   `LRC_ASSERT_IMPL(a_count_range, rsp_valid_ff,
      rsp_ff.byte_count != 3'd0 && rsp_ff.byte_count <= 3'd4, "byte count out of range")
   `LRC_ASSERT_IMPL(a_inside_nonneg, rsp_valid_ff && rsp_ff.inside_res,
      !rsp_ff.pixel_x[15] && !rsp_ff.pixel_y[15], "negative point marked inside")
   `LRC_ASSERT_NEXT(a_take_loads, take, rsp_valid_ff, "accepted point lost")

endmodule

FILE: hw/rtl/line_rasterizer_clipped.sv
// Clipped Bresenham line rasterizer, one pixel per load request and per step of an active line.
// A request's point is held in the walker's point register, then in the pixel result register on rsp.
// Throughput: one request per cycle while rsp_ready holds; the walker's combinational step update sets it.
// Ready runs back through both stages; a stalled result stops input once both are full.
// Reset (synchronous) clears the walk, empties both stages and sets 32 bpp, other sizes 0.
// Depends on lrc_pkg, lrc_walker and lrc_pixel_gen.
module line_rasterizer_clipped #(
   parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lrc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrc_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   lrc_pkg::cfg_type cfg_ff, cfg_in;
   logic             pt_valid;
   logic             pt_ready;
   lrc_pkg::pt_type  pt;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lrc_pkg::CSR_FB_WIDTH:  cfg_in.fb_width       = csr_wdata[14:0];
            lrc_pkg::CSR_FB_HEIGHT: cfg_in.fb_height      = csr_wdata[14:0];
            lrc_pkg::CSR_ROW_PITCH: cfg_in.row_pitch      = csr_wdata[16:0];
            lrc_pkg::CSR_BPP:       cfg_in.bits_per_pixel = csr_wdata[5:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_width       <= '0;
         cfg_ff.fb_height      <= '0;
         cfg_ff.row_pitch      <= '0;
         cfg_ff.bits_per_pixel <= lrc_pkg::BPP_32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lrc_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .pt_valid   (pt_valid),
      .pt_ready   (pt_ready),
      .pt         (pt)
   );

   lrc_pixel_gen u_pixel_gen (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pt_valid   (pt_valid),
      .pt_ready   (pt_ready),
      .pt         (pt),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for line_rasterizer_clipped: line loads and steps go in, clipped pixels come out.
// Each pixel is checked against a Bresenham walker kept in the bench, under several formats and idle patterns.
// Depends on lrc_pkg and the line_rasterizer_clipped RTL.
module tb;
   import lrc_pkg::*;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 190;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow of the format registers
   logic [14:0] fb_w = '0;
   logic [14:0] fb_h = '0;
   logic [16:0] pitch = '0;
   logic [5:0]  bpp = BPP_32;

   // walker state
   logic signed [15:0] pos_x = '0;
   logic signed [15:0] pos_y = '0;
   logic signed [15:0] tgt_x = '0;
   logic signed [15:0] tgt_y = '0;
   logic signed [16:0] run_x = '0;
   logic signed [17:0] neg_run_y = '0;
   logic signed [18:0] err_acc = '0;
   logic        x_back = 1'b0;
   logic        y_back = 1'b0;
   logic [31:0] ink = '0;
   logic        walking = 1'b0;

   req_type requests_todo[$];
   rsp_type pixels_due[$];
   int requests_issued = 0;
   int requests_taken = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;
   logic drain_hold = 1'b0;

   line_rasterizer_clipped dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin : watchdog
      wait (cycle_count >= RUN_LIMIT);
      $display("line_rasterizer_clipped verification failed");
      $finish;
   end

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // pixel at the current walker position under the current format
   function automatic rsp_type pixel_here();
      rsp_type     p;
      logic [2:0]  nbytes;
      logic [31:0] data;
      case (bpp)
         BPP_16: begin
            nbytes = 3'd2;
            data = {16'h0, ink[15:0]};
         end
         BPP_24: begin
            nbytes = 3'd3;
            data = {8'h0, ink[23:0]};
         end
         BPP_32: begin
            nbytes = 3'd4;
            data = ink;
         end
         default: begin
            nbytes = 3'd1;
            data = {24'h0, ink[7:0]};
         end
      endcase
      p.pixel_x = pos_x;
      p.pixel_y = pos_y;
      p.inside_res = pos_x >= 0 && pos_y >= 0 &&
                     int'(pos_x) < int'(fb_w) && int'(pos_y) < int'(fb_h);
      p.byte_offset = p.inside_res ?
                      32'(int'(pos_y)) * 32'(pitch) + 32'(int'(pos_x)) * 32'(nbytes) : 32'h0;
      p.pixel_data = p.inside_res ? data : 32'h0;
      p.byte_count = nbytes;
      p.last_pixel = (pos_x == tgt_x) && (pos_y == tgt_y);
      return p;
   endfunction

   // advance the walker for one accepted request and queue the pixel it yields
   task automatic walk_request(input req_type r);
      int dx;
      int dy;
      int e2;
      if (r.command == CMD_LOAD) begin
         pos_x = r.start_x;
         pos_y = r.start_y;
         tgt_x = r.end_x;
         tgt_y = r.end_y;
         ink = r.line_color;
         dx = int'(tgt_x) - int'(pos_x);
         dy = int'(tgt_y) - int'(pos_y);
         run_x = 17'(dx < 0 ? -dx : dx);
         neg_run_y = 18'(dy < 0 ? dy : -dy);
         x_back = !(pos_x < tgt_x);
         y_back = !(pos_y < tgt_y);
         err_acc = 19'(int'(run_x) + int'(neg_run_y));
         walking = !(pos_x == tgt_x && pos_y == tgt_y);
         pixels_due.push_back(pixel_here());
      end else if (walking) begin
         e2 = 2 * int'(err_acc);
         if (e2 >= int'(neg_run_y)) begin
            err_acc = err_acc + neg_run_y;
            pos_x = x_back ? pos_x - 16'sd1 : pos_x + 16'sd1;
         end
         if (e2 <= int'(run_x)) begin
            err_acc = err_acc + run_x;
            pos_y = y_back ? pos_y - 16'sd1 : pos_y + 16'sd1;
         end
         if (pos_x == tgt_x && pos_y == tgt_y) walking = 1'b0;
         pixels_due.push_back(pixel_here());
      end
   endtask

   always @(posedge clock) begin : request_driver
      logic fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            walk_request(req_payload);
            requests_taken++;
            // hold off now and then until the pipeline runs dry
            if (requests_taken % 97 == 50) drain_hold = 1'b1;
         end
         if (drain_hold && pixels_due.size() == 0) drain_hold = 1'b0;
         if (fire || !req_valid) begin
            if (requests_todo.size() != 0 && !drain_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_payload <= requests_todo.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("pixel mismatch: %s", what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) report_mismatch($sformatf("%s expected %h got %h", name, want, got));
   endtask

   always @(posedge clock) begin : pixel_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel at (%0d,%0d)",
                                         rsp_payload.pixel_x, rsp_payload.pixel_y));
            end else begin
               want = pixels_due.pop_front();
               compare_field("pixel_x", 32'(want.pixel_x), 32'(rsp_payload.pixel_x));
               compare_field("pixel_y", 32'(want.pixel_y), 32'(rsp_payload.pixel_y));
               compare_field("inside_res", 32'(want.inside_res), 32'(rsp_payload.inside_res));
               compare_field("byte_offset", want.byte_offset, rsp_payload.byte_offset);
               compare_field("pixel_data", want.pixel_data, rsp_payload.pixel_data);
               compare_field("byte_count", 32'(want.byte_count), 32'(rsp_payload.byte_count));
               compare_field("last_pixel", 32'(want.last_pixel), 32'(rsp_payload.last_pixel));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic add_req(input logic cmd, input int sx, input int sy, input int ex,
                          input int ey, input logic [31:0] color);
      req_type r;
      r.command = cmd;
      r.start_x = 16'(sx);
      r.start_y = 16'(sy);
      r.end_x = 16'(ex);
      r.end_y = 16'(ey);
      r.line_color = color;
      requests_todo.push_back(r);
      requests_issued++;
   endtask

   // load a line, then issue steps carrying junk in the ignored fields
   task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [31:0] color, input int nsteps);
      add_req(CMD_LOAD, sx, sy, ex, ey, color);
      repeat (nsteps) add_req(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic int pick_coord(input int limit);
      int v;
      case ($urandom_range(3))
         0: v = int'($urandom_range(60)) - 12;
         1: v = limit + int'($urandom_range(24)) - 12;
         2: v = int'($urandom_range(limit));
         default: v = $signed(16'($urandom));
      endcase
      return clamp16(v);
   endfunction

   task automatic add_random(input int target);
      int made;
      int kind;
      int span;
      int sx;
      int sy;
      int ex;
      int ey;
      int ax;
      int ay;
      int nsteps;
      made = 0;
      while (made < target) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // complete walk, sometimes followed by steps past the end
            span = ($urandom_range(9) == 0) ? 150 : 20;
            sx = pick_coord(int'(fb_w));
            sy = pick_coord(int'(fb_h));
            ex = clamp16(sx + int'($urandom_range(2 * span)) - span);
            ey = clamp16(sy + int'($urandom_range(2 * span)) - span);
            ax = ex > sx ? ex - sx : sx - ex;
            ay = ey > sy ? ey - sy : sy - ey;
            nsteps = ax > ay ? ax : ay;
            add_line(sx, sy, ex, ey, $urandom,
                     nsteps + (($urandom_range(3) == 0) ? int'($urandom_range(1, 3)) : 0));
            made += 1 + nsteps;
         end else if (kind < 85) begin
            // long line cut short by the next load
            nsteps = $urandom_range(12);
            add_line($signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)), $urandom, nsteps);
            made += 1 + nsteps;
         end else begin
            add_req(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
            made++;
         end
      end
   endtask

   // wait until every request is taken and every pixel has come back
   task automatic settle();
      while (requests_taken != requests_issued || pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] keep;
      logic [31:0] word;
      case (idx)
         CSR_FB_WIDTH, CSR_FB_HEIGHT: keep = 32'h7FFF;
         CSR_ROW_PITCH: keep = 32'h1FFFF;
         default: keep = 32'h3F;
      endcase
      // junk above the register width must be dropped
      word = ($urandom & ~keep) | (val & keep);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FB_WIDTH: fb_w = word[14:0];
         CSR_FB_HEIGHT: fb_h = word[14:0];
         CSR_ROW_PITCH: pitch = word[16:0];
         default: bpp = word[5:0];
      endcase
   endtask

   task automatic set_format(input int w, input int h, input int p, input logic [5:0] b);
      write_reg(CSR_FB_WIDTH, 32'(w));
      write_reg(CSR_FB_HEIGHT, 32'(h));
      write_reg(CSR_ROW_PITCH, 32'(p));
      write_reg(CSR_BPP, 32'(b));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [5:0] random_bpp();
      case ($urandom_range(4))
         0: return BPP_8;
         1: return BPP_16;
         2: return BPP_24;
         3: return BPP_32;
         default: return 6'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset format: nothing visible, 32 bpp
      add_line(0, 0, 0, 0, 32'hA5C3_0F96, 0);
      add_req(CMD_STEP, -1, -1, -1, -1, 32'hFFFF_FFFF);
      add_line(2, 3, 4, 3, 32'h0102_0304, 2);
      settle();

      set_format(64, 48, 256, BPP_24);
      add_line(0, 0, 3, 1, 32'hFFFF_FFFF, 4);
      add_line(5, 5, 2, 9, 32'h0000_0000, 4);
      add_line(-32768, -32768, 32767, 32767, 32'h8000_0001, 2);
      add_line(32767, -32768, -32768, 32767, 32'h7FFF_FFFE, 1);
      add_line(63, 47, 64, 48, 32'h1234_5678, 2);
      add_line(-1, 0, 0, 0, 32'hDEAD_BEEF, 1);
      settle();

      for (p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 78;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 78;
            end
            default: begin
               send_idle_pct = 19;
               recv_stall_pct = 19;
            end
         endcase
         case (p)
            0: set_format(64, 48, 256, BPP_8);
            1: set_format(0, 0, 0, BPP_16);
            2: set_format(32767, 32767, 131071, BPP_32);
            3: set_format($urandom_range(1, 300), $urandom_range(1, 300),
                          $urandom_range(131071), BPP_24);
            4: set_format(1, 1, $urandom_range(131071), 6'd63);
            default: set_format(($urandom_range(3) == 0) ? $urandom_range(32767)
                                                         : $urandom_range(400),
                                ($urandom_range(3) == 0) ? $urandom_range(32767)
                                                         : $urandom_range(400),
                                $urandom_range(131071), random_bpp());
         endcase
         add_random(PHASE_ITEMS);
         settle();
      end

      if (mismatches == 0) begin
         $display("line_rasterizer_clipped verification clean");
      end else begin
         $display("line_rasterizer_clipped verification failed");
      end
      $finish;
   end
endmodule
